[design/fbpa_pkg.sv]
// Package for the fixed-size block pool allocator.
// Holds the widths, codes, payload structs and controller/datapath command types.
// No dependencies.
package fbpa_pkg;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 13;
  localparam int POOL_BYTES  = 4096;
  localparam int ALIGN_BYTES = 4;
  localparam int MAX_BLOCKS  = 1024;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int LINK_W      = IDX_W + 1;
  localparam int PROD_W      = LINK_W + SIZE_W;
  localparam int CNT_W       = $clog2(ADDR_W);
  localparam int CFG_IDX_W   = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_TOO_BIG = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_POOL  = 2'd1,
    CFG_BLOCK = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] free_bytes;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT_DIV,
    ST_INIT_FILL,
    ST_ALLOC_UPD,
    ST_REL_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_INIT_CHECK,
    DP_INIT_COUNT,
    DP_FILL,
    DP_ALLOC_READ,
    DP_ALLOC_EMPTY,
    DP_ALLOC_UPD,
    DP_DIV_REL,
    DP_REL_LINK,
    DP_PASS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } fbpa_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       init_err;
    logic       alloc_empty;
    logic       rel_skip;
    logic       div_done;
    logic       fill_last;
  } fbpa_sts_t;

endpackage

[design/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used for the block count at init and the block index at release. Depends on fbpa_pkg.
module fbpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                       done,
  output logic [fbpa_pkg::ADDR_W-1:0] quotient
);
  import fbpa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] dq_r, dq_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [SIZE_W:0]   shifted;
  logic              ge;

  always_comb begin
    shifted  = {rem_r, dq_r[ADDR_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? SIZE_W'(shifted - {1'b0, dvs_r}) : shifted[SIZE_W-1:0];
      dq_nxt  = {dq_r[ADDR_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

[design/fbpa_datapath.sv]
// Datapath of the block pool allocator: configuration, free-list memory, head and counters.
// Depends on fbpa_pkg and fbpa_div; driven by commands from fbpa_ctrl.
module fbpa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
  input  fbpa_pkg::in_item_t             in_item,
  input  fbpa_pkg::fbpa_cmd_t            cmd,
  output fbpa_pkg::fbpa_sts_t            sts,
  output fbpa_pkg::out_item_t            out_item
);
  import fbpa_pkg::*;

  logic [LINK_W-1:0] link_mem [MAX_BLOCKS];

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [SIZE_W-1:0] pool_r, pool_nxt;
  logic [SIZE_W-1:0] blkreq_r, blkreq_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [SIZE_W-1:0] al_r, al_nxt;
  logic [LINK_W-1:0] count_r, count_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LINK_W-1:0] fill_r, fill_nxt;
  logic [LINK_W-1:0] rd_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;

  logic [SIZE_W-1:0] pool_used;
  logic [SIZE_W-1:0] req;
  logic [SIZE_W:0]   al_wide;
  logic [SIZE_W-1:0] al_calc;
  logic              init_err;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_dividend;
  logic [SIZE_W-1:0] div_divisor;
  logic [ADDR_W-1:0] quotient;
  logic [LINK_W-1:0] fill_next;
  logic              fill_last;
  logic              rel_hit;
  logic [SIZE_W:0]   free_sum;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;

  assign pool_used = (pool_r > SIZE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES) : pool_r;
  assign req       = (blkreq_r == '0) ? SIZE_W'(1) : blkreq_r;
  assign al_wide   = ({1'b0, req} + (SIZE_W+1)'(ALIGN_BYTES - 1))
                     & ~(SIZE_W+1)'(ALIGN_BYTES - 1);
  assign al_calc   = al_wide[SIZE_W-1:0];
  assign init_err  = al_wide > {1'b0, pool_used};
  assign fill_next = fill_r + LINK_W'(1);
  assign fill_last = fill_next == count_r;
  assign rel_hit   = quotient < ADDR_W'(count_r);
  assign free_sum  = {1'b0, free_r} + {1'b0, al_r};

  assign div_start    = ((cmd.op == DP_INIT_CHECK) && !init_err) || (cmd.op == DP_DIV_REL);
  assign div_dividend = (cmd.op == DP_DIV_REL) ? (addr_r - base_r) : ADDR_W'(pool_used);
  assign div_divisor  = (cmd.op == DP_DIV_REL) ? al_r : al_calc;

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    base_nxt   = base_r;
    pool_nxt   = pool_r;
    blkreq_nxt = blkreq_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:  base_nxt   = cfg_data;
        CFG_POOL:  pool_nxt   = cfg_data[SIZE_W-1:0];
        CFG_BLOCK: blkreq_nxt = cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    head_nxt  = head_r;
    free_nxt  = free_r;
    al_nxt    = al_r;
    count_nxt = count_r;
    mode_nxt  = mode_r;
    addr_nxt  = addr_r;
    fill_nxt  = fill_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = fill_r[IDX_W-1:0];
    mem_wdata = fill_last ? NULL_LINK : fill_next;
    mem_re    = 1'b0;
    unique case (cmd.op)
      DP_CAPTURE: begin
        mode_nxt = in_item.mode;
        addr_nxt = in_item.release_address;
      end
      DP_INIT_CHECK: begin
        al_nxt = al_calc;
        if (init_err) begin
          head_nxt  = NULL_LINK;
          count_nxt = '0;
          free_nxt  = '0;
          res_nxt   = '{status: STAT_TOO_BIG, block_address: '0, free_bytes: '0};
        end
      end
      DP_INIT_COUNT: begin
        count_nxt = (quotient > ADDR_W'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS)
                                                     : quotient[LINK_W-1:0];
        fill_nxt  = '0;
      end
      DP_FILL: begin
        mem_we   = 1'b1;
        fill_nxt = fill_next;
        if (fill_last) begin
          head_nxt = '0;
          free_nxt = pool_used;
          res_nxt  = '{status: STAT_OK, block_address: '0, free_bytes: pool_used};
        end
      end
      DP_ALLOC_READ: begin
        mem_re   = 1'b1;
        prod_nxt = PROD_W'(head_r) * PROD_W'(al_r);
      end
      DP_ALLOC_EMPTY: begin
        res_nxt = '{status: STAT_EMPTY, block_address: '0, free_bytes: free_r};
      end
      DP_ALLOC_UPD: begin
        head_nxt = rd_r;
        free_nxt = (free_r >= al_r) ? (free_r - al_r) : '0;
        res_nxt  = '{status: STAT_OK, block_address: base_r + ADDR_W'(prod_r),
                     free_bytes: free_nxt};
      end
      DP_REL_LINK: begin
        if (rel_hit) begin
          mem_we    = 1'b1;
          mem_waddr = quotient[IDX_W-1:0];
          mem_wdata = head_r;
          head_nxt  = quotient[LINK_W-1:0];
          free_nxt  = (free_sum > {1'b0, pool_used}) ? pool_used : free_sum[SIZE_W-1:0];
        end
        res_nxt = '{status: STAT_OK, block_address: '0, free_bytes: free_nxt};
      end
      DP_PASS: begin
        res_nxt = '{status: STAT_OK, block_address: '0, free_bytes: free_r};
      end
      default: ;
    endcase
    out_nxt = cmd.out_load ? res_r : out_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= link_mem[head_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pool_r   <= SIZE_W'(POOL_BYTES);
      blkreq_r <= SIZE_W'(16);
      head_r   <= NULL_LINK;
      free_r   <= '0;
      al_r     <= '0;
      count_r  <= '0;
    end else begin
      base_r   <= base_nxt;
      pool_r   <= pool_nxt;
      blkreq_r <= blkreq_nxt;
      head_r   <= head_nxt;
      free_r   <= free_nxt;
      al_r     <= al_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    addr_r <= addr_nxt;
    fill_r <= fill_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign sts = '{mode:        mode_r,
                 init_err:    init_err,
                 alloc_empty: (head_r >= NULL_LINK) || (head_r >= count_r),
                 rel_skip:    (al_r == '0) || (count_r == '0),
                 div_done:    div_done,
                 fill_last:   fill_last};

  assign out_item = out_r;

endmodule

[design/fbpa_ctrl.sv]
// Controller state machine of the block pool allocator.
// Sequences each item through the datapath and owns the channel handshakes. Depends on fbpa_pkg.
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fbpa_pkg::fbpa_sts_t sts,
  output fbpa_pkg::fbpa_cmd_t cmd
);
  import fbpa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = DP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.mode)
          MODE_INIT: begin
            cmd.op    = DP_INIT_CHECK;
            state_nxt = sts.init_err ? ST_FINISH : ST_INIT_DIV;
          end
          MODE_ALLOC: begin
            if (sts.alloc_empty) begin
              cmd.op    = DP_ALLOC_EMPTY;
              state_nxt = ST_FINISH;
            end else begin
              cmd.op    = DP_ALLOC_READ;
              state_nxt = ST_ALLOC_UPD;
            end
          end
          MODE_RELEASE: begin
            if (sts.rel_skip) begin
              cmd.op    = DP_PASS;
              state_nxt = ST_FINISH;
            end else begin
              cmd.op    = DP_DIV_REL;
              state_nxt = ST_REL_DIV;
            end
          end
          MODE_NOP: begin
            cmd.op    = DP_PASS;
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_INIT_DIV: begin
        if (sts.div_done) begin
          cmd.op    = DP_INIT_COUNT;
          state_nxt = ST_INIT_FILL;
        end
      end
      ST_INIT_FILL: begin
        cmd.op = DP_FILL;
        if (sts.fill_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_ALLOC_UPD: begin
        cmd.op    = DP_ALLOC_UPD;
        state_nxt = ST_FINISH;
      end
      ST_REL_DIV: begin
        if (sts.div_done) begin
          cmd.op    = DP_REL_LINK;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/fixed_block_pool_allocator_core.sv]
// Top level of the fixed-size block pool allocator with a last-in first-out free list.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_datapath.
//
// Usage:
//   The input channel (in_valid, in_ready, in_item) carries one request: init, allocate,
//   release or no operation. Each request gives exactly one result on the output channel
//   (out_valid, out_ready, out_item) with a status, the block address and the free count.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
//   and sets base address, pool size and block size; the user must write it only while the
//   block is idle, which the block itself does not enforce. One request is in work at a
//   time. Empty allocates, skipped releases, oversized inits and no operations go from
//   dispatch straight to the finishing state; an allocate passes the update state, a release
//   waits in the divide state for the divider, and an init waits for the divider and then
//   fills the free list through the single write port of its memory. The next request is
//   taken in the cycle after the result is loaded.
//   The result sits in an output register, so a new request is taken while it waits;
//   if the receiver stalls, the following result waits in the finishing state.
//   Reset restores the configuration defaults, empties the free list and clears the free
//   count; the free-list memory itself is not cleared, and an init must precede allocation.
module fixed_block_pool_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fbpa_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fbpa_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

[design/fbpa_checker.sv]
// Port-level checker for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core.
module fbpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input fbpa_pkg::out_item_t out_item
);
  import fbpa_pkg::*;

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid straight after reset.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result changed or was dropped.");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != STAT_OK) |-> out_item.block_address == '0)
    else $error("Failed request returned a non-zero block address.");

  a_too_big_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == STAT_TOO_BIG) |-> out_item.free_bytes == '0)
    else $error("Oversized init left a non-zero free count.");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.free_bytes <= SIZE_W'(POOL_BYTES))
                  && (out_item.status <= STAT_TOO_BIG))
    else $error("Free count above the pool size or unknown status code.");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
